### src/shst_pkg.sv
// Shared constants and types for the stack hash signature table.
// No dependencies; every other file imports this package.
package shst_pkg;

	localparam int unsigned TABLE_ENTRIES_DEFAULT = 32;
	localparam int unsigned MAX_FRAMES_DEFAULT    = 32;

	localparam int unsigned HASH_W    = 32;
	localparam logic [HASH_W-1:0] HASH_SEED = 32'hDEADC0DE;
	localparam int unsigned ROTATE_BY = 5;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
		logic              hit;
	} qry_t;

	function automatic logic [HASH_W-1:0] rotl_hash(input logic [HASH_W-1:0] v);
		rotl_hash = {v[HASH_W-1-ROTATE_BY:0], v[HASH_W-1:HASH_W-ROTATE_BY]};
	endfunction

endpackage

### src/shst_if.sv
// Handshake channels for frame transactions in and result transactions out.
// Depends on shst_pkg for the hash width.
interface shst_in_if import shst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] frame_address;
	logic              frame_present;
	logic              last_frame;
	logic              operation;

	modport source (output valid, frame_address, frame_present, last_frame, operation,
		input ready);
	modport sink (input valid, frame_address, frame_present, last_frame, operation,
		output ready);
endinterface

interface shst_out_if import shst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] stack_hash;
	logic              is_known;
	logic              was_recorded;
	logic              table_full;
	logic              frames_dropped;

	modport source (output valid, stack_hash, is_known, was_recorded, table_full,
		frames_dropped, input ready);
	modport sink (input valid, stack_hash, is_known, was_recorded, table_full,
		frames_dropped, output ready);
endinterface

### src/shst_hasher.sv
// Running trace hash: xor-rotate-add per frame, frame counter, overflow flag.
// Depends on shst_pkg.
module shst_hasher import shst_pkg::*; #(
	parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [HASH_W-1:0] frame_address,
	input  logic              frame_present,
	input  logic              last_frame,
	output logic [HASH_W-1:0] next_hash,
	output logic              next_overflow
);
	localparam int unsigned IDX_W = $clog2(MAX_FRAMES + 1);

	logic [HASH_W-1:0] hash_q;
	logic [IDX_W-1:0]  idx_q;
	logic              ovf_q;
	logic              take;

	assign take          = frame_present && (idx_q < IDX_W'(MAX_FRAMES));
	assign next_hash     = take ? rotl_hash(hash_q ^ frame_address) + HASH_W'(idx_q) : hash_q;
	assign next_overflow = ovf_q | (frame_present & ~take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			idx_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			if (last_frame) begin
				hash_q <= HASH_SEED;
				idx_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				hash_q <= next_hash;
				ovf_q  <= next_overflow;
				if (take) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end
endmodule

### src/shst_cell.sv
// One signature cell: holds one entry, shifts it to its neighbor on record,
// and passes the lookup query one cell per cycle with its running hit flag.
// Depends on shst_pkg.
module shst_cell import shst_pkg::*; #(
	parameter int unsigned CNT_W = 6,
	parameter int unsigned IDX   = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  logic [HASH_W-1:0] shift_in,
	output logic [HASH_W-1:0] entry,
	input  logic [CNT_W-1:0]  count,
	input  qry_t              qry_in,
	output qry_t              qry_out
);
	logic [HASH_W-1:0] entry_q;
	logic              valid_q;
	logic [HASH_W-1:0] hash_q;
	logic              hit_q;
	logic              filled;

	assign filled = count > CNT_W'(IDX);
	assign entry  = entry_q;
	assign qry_out = '{valid: valid_q, hash: hash_q, hit: hit_q};

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= shift_in;
		end
		hash_q <= qry_in.hash;
		hit_q  <= qry_in.hit | (qry_in.valid & filled & (entry_q == qry_in.hash));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= qry_in.valid;
		end
	end
endmodule

### src/stack_hash_signature_table.sv
// Stack hash signature table: hashes one frame transaction per cycle if ready.
// Frames not ending a trace are taken every cycle while no result is pending.
// A record's result is registered in the cycle after its last frame; a lookup
// walks the TABLE_ENTRIES cells, one cell per cycle, into the output register.
// One trace end is in flight at a time; input stalls until its result is taken.
// Reset empties the table and restarts the hash at its seed at once.
module stack_hash_signature_table import shst_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
	parameter int unsigned MAX_FRAMES    = MAX_FRAMES_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	shst_in_if.sink    trace,
	shst_out_if.source verdict
);
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic              accept;
	logic              end_trace;
	logic              has_room;
	logic              shift_en;
	logic [HASH_W-1:0] next_hash;
	logic              next_overflow;
	logic [CNT_W-1:0]  count_q;
	logic              pend_q;
	logic              drop_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;
	logic              out_known_q;
	logic              out_recorded_q;
	logic              out_full_q;
	logic              out_dropped_q;

	logic [HASH_W-1:0] entries [TABLE_ENTRIES];
	qry_t              qry     [TABLE_ENTRIES+1];

	assign trace.ready = ~pend_q;
	assign accept      = trace.valid & ~pend_q;
	assign end_trace   = accept & trace.last_frame;
	assign has_room    = count_q < CNT_W'(TABLE_ENTRIES);
	assign shift_en    = end_trace & (trace.operation == OP_RECORD) & has_room;

	assign qry[0] = '{valid: end_trace & (trace.operation == OP_LOOKUP),
		hash: next_hash, hit: 1'b0};

	shst_hasher #(.MAX_FRAMES(MAX_FRAMES)) u_hasher (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.frame_address (trace.frame_address),
		.frame_present (trace.frame_present),
		.last_frame    (trace.last_frame),
		.next_hash     (next_hash),
		.next_overflow (next_overflow)
	);

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		shst_cell #(.CNT_W(CNT_W), .IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.shift_in ((k == 0) ? next_hash : entries[(k == 0) ? 0 : k-1]),
			.entry    (entries[k]),
			.count    (count_q),
			.qry_in   (qry[k]),
			.qry_out  (qry[k+1])
		);
	end

	assign verdict.valid          = out_valid_q;
	assign verdict.stack_hash     = out_hash_q;
	assign verdict.is_known       = out_known_q;
	assign verdict.was_recorded   = out_recorded_q;
	assign verdict.table_full     = out_full_q;
	assign verdict.frames_dropped = out_dropped_q;

	always_ff @(posedge clk) begin
		if (end_trace) begin
			drop_q <= next_overflow;
		end
		if (end_trace && trace.operation == OP_RECORD) begin
			out_hash_q     <= next_hash;
			out_known_q    <= 1'b0;
			out_recorded_q <= has_room;
			out_full_q     <= ~has_room;
			out_dropped_q  <= next_overflow;
		end else if (qry[TABLE_ENTRIES].valid) begin
			out_hash_q     <= qry[TABLE_ENTRIES].hash;
			out_known_q    <= qry[TABLE_ENTRIES].hit;
			out_recorded_q <= 1'b0;
			out_full_q     <= 1'b0;
			out_dropped_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (shift_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (end_trace) begin
				pend_q <= 1'b1;
			end else if (out_valid_q && verdict.ready) begin
				pend_q <= 1'b0;
			end
			if ((end_trace && trace.operation == OP_RECORD) || qry[TABLE_ENTRIES].valid) begin
				out_valid_q <= 1'b1;
			end else if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### tb/sv/tb_stack_hash_signature_table.sv
// Self-checking testbench for stack_hash_signature_table: drives frame transactions, predicts
// each trace verdict in a local hash/table model and compares every result transaction.
// Depends on shst_pkg, shst_in_if / shst_out_if and the stack_hash_signature_table RTL.
module tb_stack_hash_signature_table;
	import shst_pkg::*;

	localparam int unsigned TABLE_N     = TABLE_ENTRIES_DEFAULT;
	localparam int unsigned FRAME_N     = MAX_FRAMES_DEFAULT;
	localparam int unsigned ITEM_TARGET = 1600;
	localparam int unsigned QUIET_AFTER = 1400;
	localparam int unsigned HOLD_AT     = 600;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DIR_ROWS    = 16;
	localparam int unsigned LOG_DEPTH   = 64;

	typedef struct packed {
		logic [HASH_W-1:0] address;
		logic              present;
		logic              last;
		logic              op;
	} frame_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              known;
		logic              recorded;
		logic              full;
		logic              dropped;
	} verdict_t;

	typedef struct {
		frame_t   item;
		int       reps;
		bit       typed;
		verdict_t typed_v;
	} stim_row_t;

	typedef struct {
		logic [HASH_W-1:0] base;
		logic [HASH_W-1:0] stride;
		int unsigned       len;
	} trace_shape_t;

	logic clk;
	logic arst_n;

	shst_in_if  trace ();
	shst_out_if verdict ();

	stack_hash_signature_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.trace(trace),
		.verdict(verdict)
	);

	logic [HASH_W-1:0] trace_hash;
	int unsigned       trace_depth;
	logic              trace_overflow;
	logic [HASH_W-1:0] signature_mem [TABLE_N];
	int unsigned       signature_fill;

	verdict_t     pending_verdicts [$];
	trace_shape_t trace_log [LOG_DEPTH];
	int unsigned  trace_log_n;
	int unsigned  sent_items;
	int unsigned  fail_count;
	int unsigned  cycles;
	bit           idle_on;
	bit           hold_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_stack_hash_signature_table failed");
			$finish;
		end
	end

	function automatic bit predict_verdict(input frame_t f, output verdict_t v);
		v = '0;
		if (f.present) begin
			if (trace_depth < FRAME_N) begin
				trace_hash = trace_hash ^ f.address;
				trace_hash = ((trace_hash << 5) | (trace_hash >> 27)) + trace_depth;
				trace_depth++;
			end else begin
				trace_overflow = 1'b1;
			end
		end
		if (!f.last)
			return 1'b0;
		if (f.op == OP_RECORD) begin
			if (signature_fill < TABLE_N) begin
				signature_mem[signature_fill] = trace_hash;
				signature_fill++;
				v.recorded = 1'b1;
			end else begin
				v.full = 1'b1;
			end
		end else begin
			for (int i = 0; i < signature_fill; i++)
				if (signature_mem[i] == trace_hash)
					v.known = 1'b1;
		end
		v.hash = trace_hash;
		v.dropped = trace_overflow;
		trace_hash = HASH_SEED;
		trace_depth = 0;
		trace_overflow = 1'b0;
		return 1'b1;
	endfunction

	task automatic offer_frame(input frame_t f, input bit typed, input verdict_t typed_v);
		verdict_t v;
		bit       has;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			trace.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		trace.valid <= 1'b1;
		trace.frame_address <= f.address;
		trace.frame_present <= f.present;
		trace.last_frame <= f.last;
		trace.operation <= f.op;
		do @(posedge clk); while (trace.ready !== 1'b1);
		has = predict_verdict(f, v);
		if (has)
			pending_verdicts.push_back(typed ? typed_v : v);
		if (f.present || f.last)
			sent_items++;
	endtask

	task automatic emit_trace(input trace_shape_t t, input logic op, input bit bare_end);
		frame_t f;
		for (int unsigned i = 0; i < t.len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				f.address = $urandom;
				f.present = 1'b0;
				f.last = 1'b0;
				f.op = logic'($urandom_range(0, 1));
				offer_frame(f, 1'b0, '0);
			end
			f.address = t.base ^ (t.stride * i);
			f.present = 1'b1;
			f.last = (i == t.len - 1) && !bare_end;
			f.op = f.last ? op : logic'($urandom_range(0, 1));
			offer_frame(f, 1'b0, '0);
		end
		if (bare_end || t.len == 0) begin
			f.address = $urandom;
			f.present = 1'b0;
			f.last = 1'b1;
			f.op = op;
			offer_frame(f, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic [HASH_W-1:0] exp,
		input logic [HASH_W-1:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %h, actual %h", name, exp, act);
			fail_count++;
		end
	endtask

	initial begin
		verdict_t exp;
		int       hold_cnt;
		hold_cnt = 0;
		verdict.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (verdict.valid === 1'b1 && verdict.ready === 1'b1) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result transaction: stack_hash %h", verdict.stack_hash);
					fail_count++;
				end else begin
					exp = pending_verdicts.pop_front();
					check_field("stack_hash", exp.hash, verdict.stack_hash);
					check_field("is_known", HASH_W'(exp.known), HASH_W'(verdict.is_known));
					check_field("was_recorded", HASH_W'(exp.recorded),
						HASH_W'(verdict.was_recorded));
					check_field("table_full", HASH_W'(exp.full), HASH_W'(verdict.table_full));
					check_field("frames_dropped", HASH_W'(exp.dropped),
						HASH_W'(verdict.frames_dropped));
				end
			end
			if (sent_items >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				verdict.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_cnt = $urandom_range(1, 4) - 1;
				verdict.ready <= 1'b0;
			end else begin
				verdict.ready <= 1'b1;
			end
		end
	end

	initial begin
		stim_row_t    directed_rows [DIR_ROWS];
		trace_shape_t t;
		logic         op;
		int unsigned  pick;
		directed_rows = '{
			'{'{32'h0000_0000, 1'b0, 1'b1, OP_LOOKUP}, 1, 1'b1, '{HASH_SEED, 1'b0, 1'b0, 1'b0, 1'b0}},
			'{'{32'hFFFF_FFFF, 1'b0, 1'b0, OP_RECORD}, 1, 1'b0, '0},
			'{'{32'h0000_0000, 1'b0, 1'b1, OP_RECORD}, 1, 1'b1, '{HASH_SEED, 1'b0, 1'b1, 1'b0, 1'b0}},
			'{'{32'h0000_0000, 1'b0, 1'b1, OP_LOOKUP}, 1, 1'b1, '{HASH_SEED, 1'b1, 1'b0, 1'b0, 1'b0}},
			'{'{32'h0000_0000, 1'b1, 1'b0, OP_RECORD}, 1, 1'b0, '0},
			'{'{32'hFFFF_FFFF, 1'b1, 1'b1, OP_RECORD}, 1, 1'b0, '0},
			'{'{32'h0000_0000, 1'b1, 1'b0, OP_LOOKUP}, 1, 1'b0, '0},
			'{'{32'hFFFF_FFFF, 1'b1, 1'b1, OP_LOOKUP}, 1, 1'b0, '0},
			'{'{32'hA5A5_A5A5, 1'b1, 1'b0, OP_RECORD}, 1, 1'b0, '0},
			'{'{32'h0000_0000, 1'b0, 1'b1, OP_LOOKUP}, 1, 1'b0, '0},
			'{'{32'h5A5A_5A5A, 1'b1, 1'b0, OP_LOOKUP}, FRAME_N, 1'b0, '0},
			'{'{32'h0000_0000, 1'b0, 1'b1, OP_RECORD}, 1, 1'b0, '0},
			'{'{32'h1234_5678, 1'b1, 1'b0, OP_RECORD}, FRAME_N + 1, 1'b0, '0},
			'{'{32'hFFFF_FFFF, 1'b1, 1'b1, OP_LOOKUP}, 1, 1'b0, '0},
			'{'{32'h8000_0001, 1'b1, 1'b1, OP_RECORD}, 1, 1'b0, '0},
			'{'{32'h7FFF_FFFE, 1'b1, 1'b1, OP_LOOKUP}, 1, 1'b0, '0}
		};
		trace_hash = HASH_SEED;
		trace_depth = 0;
		trace_overflow = 1'b0;
		signature_fill = 0;
		trace_log_n = 0;
		sent_items = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		trace.valid <= 1'b0;
		trace.frame_address <= '0;
		trace.frame_present <= 1'b0;
		trace.last_frame <= 1'b0;
		trace.operation <= OP_LOOKUP;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			for (int k = 0; k < directed_rows[r].reps; k++)
				offer_frame(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].typed_v);

		while (sent_items < ITEM_TARGET) begin
			idle_on = (sent_items < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
			if (trace_log_n > 0 && $urandom_range(0, 4) == 0) begin
				pick = $urandom_range(0, (trace_log_n < LOG_DEPTH ? trace_log_n : LOG_DEPTH) - 1);
				t = trace_log[pick];
				op = ($urandom_range(0, 3) == 0) ? OP_RECORD : OP_LOOKUP;
			end else begin
				t.base = $urandom;
				t.stride = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 5)
					t.len = 0;
				else if (pick < 65)
					t.len = $urandom_range(1, 6);
				else if (pick < 85)
					t.len = $urandom_range(7, FRAME_N - 1);
				else
					t.len = $urandom_range(FRAME_N, FRAME_N + 8);
				op = $urandom_range(0, 1) ? OP_RECORD : OP_LOOKUP;
				trace_log[trace_log_n % LOG_DEPTH] = t;
				trace_log_n++;
			end
			emit_trace(t, op, $urandom_range(0, 9) == 0);
		end
		trace.valid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (TABLE_N + 8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_stack_hash_signature_table passed");
		else
			$display("tb_stack_hash_signature_table failed");
		$finish;
	end
endmodule
